### design/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Delayed form of the check above: the consequent must hold after the antecedent, not with it.
`define ASSERT_AFTER2(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

### design/ssnf_pkg.sv
package ssnf_pkg;

  localparam logic [1:0] MaxZeroPos = 2'd2;

  localparam logic signed [15:0] TopDecimal = 16'sd999;
  localparam logic signed [15:0] BottomDecimal = -16'sd99;

  // Character codes used by the display texts.
  localparam logic [7:0] CHAR_BLANK = 8'd32;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_F = 8'h46;
  localparam logic [7:0] CHAR_L = 8'h4C;
  localparam logic [7:0] CHAR_V = 8'h56;
  localparam logic [7:0] CHAR_H = 8'h68;

  typedef enum logic [1:0] {
    STATUS_NORMAL = 2'd0,
    STATUS_OVER   = 2'd1,
    STATUS_UNDER  = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] left;
    logic [7:0] middle;
    logic [7:0] right;
    status_t    status;
  } result_t;

  // Character generator, one bit per lit segment.
  localparam logic [7:0] GLYPHS [64] = '{
    8'h00, 8'h30, 8'h22, 8'h14, 8'h2D, 8'h1B, 8'h70, 8'h20,
    8'h39, 8'h0F, 8'h63, 8'h46, 8'h10, 8'h40, 8'h80, 8'h52,
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h09, 8'h36, 8'h58, 8'h48, 8'h4C, 8'h53,
    8'h5F, 8'h77, 8'h7C, 8'h58, 8'h5E, 8'h79, 8'h71, 8'h3D,
    8'h74, 8'h10, 8'h1E, 8'h76, 8'h38, 8'h37, 8'h54, 8'h5C,
    8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h3E, 8'h2A,
    8'h49, 8'h6E, 8'h5B, 8'h31, 8'h64, 8'h0E, 8'h23, 8'h08
  };

  // Codes 0..15 are hex digits, 16..31 and above 127 are blank, and
  // lower case folds onto upper case.
  function automatic logic [7:0] glyph_of(input logic [7:0] c);
    logic [7:0] k;
    if (c <= 8'd9) begin
      k = c + 8'd16;
    end else if (c <= 8'd15) begin
      k = c + 8'd23;
    end else if (c <= 8'd31) begin
      k = 8'd0;
    end else if (c <= 8'd95) begin
      k = c - 8'd32;
    end else if (c <= 8'd127) begin
      k = c - 8'd64;
    end else begin
      k = 8'd0;
    end
    return GLYPHS[k[5:0]];
  endfunction

endpackage

### design/ssnf_encode.sv
module ssnf_encode (
  input  logic                req_type,
  input  logic signed [15:0]  number_value,
  input  logic [1:0]          zero_pos,
  output ssnf_pkg::result_t   result
);
  import ssnf_pkg::*;

  logic             neg;
  logic             over;
  logic             under;
  logic [15:0]      abs_value;
  logic [9:0]       mag;
  logic [3:0]       d0;
  logic [3:0]       d1;
  logic [3:0]       d2;
  logic             shown2;
  logic             shown1;
  logic             shown0;

  assign neg       = number_value[15];
  assign over      = number_value > TopDecimal;
  assign under     = number_value < BottomDecimal;
  assign abs_value = neg ? (16'd0 - number_value) : number_value;
  assign mag       = abs_value[9:0];

  // Shift-and-correct conversion with bits 9..8 preloaded into the
  // units digit, one bit of the low byte per step.
  always_comb begin
    logic [4:0] t0;
    logic [4:0] t1;
    logic       c0;
    logic       c1;
    d0 = {2'b00, mag[9:8]};
    d1 = 4'd0;
    d2 = 4'd0;
    for (int i = 7; i >= 0; i--) begin
      t0 = {d0, mag[i]};
      c0 = t0 > 5'd9;
      t0 = c0 ? (t0 - 5'd10) : t0;
      t1 = {d1, 1'b0} + {4'd0, c0};
      c1 = t1 > 5'd9;
      t1 = c1 ? (t1 - 5'd10) : t1;
      d0 = t0[3:0];
      d1 = t1[3:0];
      d2 = {d2[2:0], 1'b0} + {3'd0, c1};
    end
  end

  // A digit is shown once any higher digit is, at the pinned position,
  // or when it is nonzero. A minus sign takes the leftmost place.
  assign shown2 = !neg && ((zero_pos == 2'd2) || (d2 != 4'd0));
  assign shown1 = shown2 || (zero_pos == 2'd1) || (d1 != 4'd0);
  assign shown0 = shown1 || (zero_pos == 2'd0) || (d0 != 4'd0);

  always_comb begin
    if (req_type) begin
      result.left   = glyph_of({4'd0, number_value[7:4]});
      result.middle = glyph_of({4'd0, number_value[3:0]});
      result.right  = glyph_of(CHAR_H);
      result.status = STATUS_NORMAL;
    end else if (over) begin
      result.left   = glyph_of(CHAR_ZERO);
      result.middle = glyph_of(CHAR_F);
      result.right  = glyph_of(CHAR_L);
      result.status = STATUS_OVER;
    end else if (under) begin
      result.left   = glyph_of(CHAR_V);
      result.middle = glyph_of(CHAR_F);
      result.right  = glyph_of(CHAR_L);
      result.status = STATUS_UNDER;
    end else begin
      result.left   = neg ? glyph_of(CHAR_MINUS)
                          : glyph_of(shown2 ? {4'd0, d2} : CHAR_BLANK);
      result.middle = glyph_of(shown1 ? {4'd0, d1} : CHAR_BLANK);
      result.right  = glyph_of(shown0 ? {4'd0, d0} : CHAR_BLANK);
      result.status = STATUS_NORMAL;
    end
  end

endmodule

### design/seven_segment_number_formatter.sv
// Three-digit seven-segment number formatter.
//
// Requests arrive on the command channel: a request is taken at a rising
// clock edge with start high and busy low. busy is always low, so a new
// request may be issued in every cycle. Each request carries req_type
// (0 = signed decimal, 1 = hex byte) and number_value.
//
// Each request produces one result, shown on the segment ports and
// range_status for exactly one cycle with done high, after the request
// has been taken. Throughput is one request per cycle: the request is
// captured in an input register, formatted by one pass of logic (the
// eight-step BCD correction and the character generator lookups) and
// captured in the result register. The receiver cannot stall; it must take
// each result in the cycle done is high.
//
// The pinned zero position is written through the cfg channel, which is
// always ready; values above 2 are dropped. Synchronous reset clears the
// pipeline valid flags, drops any request in flight, and sets the pinned
// position to the rightmost digit.
module seven_segment_number_formatter (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               req_type,
  input  logic signed [15:0] number_value,
  output logic               done,
  output logic [7:0]         left_segments,
  output logic [7:0]         middle_segments,
  output logic [7:0]         right_segments,
  output logic [1:0]         range_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_data
);
  import ssnf_pkg::*;

  logic               in_valid;
  logic               in_type;
  logic signed [15:0] in_value;
  logic [1:0]         zero_pos;
  result_t            result_next;
  result_t            result;

  // The block never refuses a request or a configuration write.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration register; out-of-range positions keep the old value.
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_pos <= 2'd0;
    end else if (cfg_valid && cfg_ready && (cfg_data <= MaxZeroPos)) begin
      zero_pos <= cfg_data;
    end
  end

  // Input register stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_type  <= req_type;
      in_value <= number_value;
    end
  end

  ssnf_encode u_encode (
    .req_type     (in_type),
    .number_value (in_value),
    .zero_pos     (zero_pos),
    .result       (result_next)
  );

  // Result register stage; done marks the single cycle of each result.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      result <= result_next;
    end
  end

  assign left_segments   = result.left;
  assign middle_segments = result.middle;
  assign right_segments  = result.right;
  assign range_status    = result.status;

endmodule

### design/ssnf_checker.sv
`include "assert_macros.svh"

module ssnf_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               req_type,
  input logic               done,
  input logic [7:0]         right_segments,
  input logic [1:0]         range_status
);
  import ssnf_pkg::*;

  logic accepted;
  assign accepted = start && !busy;

  // Every request is followed by a result with done high.
  `ASSERT_AFTER2(a_result_follows, clk, rst, accepted, done, "request lost")

  // No result appears without an earlier request to match it.
  `ASSERT_IMPLIES(a_no_spurious, clk, rst, done, $past(accepted, 2), "spurious result")

  // Range texts only come from decimal requests.
  `ASSERT_IMPLIES(a_range_decimal, clk, rst,
    done && (range_status != STATUS_NORMAL), !$past(req_type, 2), "range text in hex mode")

  // Both range texts end in the letter L.
  `ASSERT_IMPLIES(a_range_text, clk, rst,
    done && (range_status != STATUS_NORMAL), right_segments == glyph_of(CHAR_L),
    "bad range text")

endmodule

bind seven_segment_number_formatter ssnf_checker u_ssnf_checker (.*);
